[design/icdf_pkg.sv]
package icdf_pkg;

    // Field widths fixed by the item format.
    localparam int MASS_W    = 17;
    localparam int RADIUS_W  = 24;
    localparam int PTS_W     = 9;
    localparam int INDEX_W   = 8;
    localparam int PROD_W    = MASS_W + RADIUS_W;
    localparam int DIV_CNT_W = $clog2(PROD_W + 1);

    // Command codes carried by the command field.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // One table entry pair as it sits in memory.
    typedef struct packed {
        logic [MASS_W-1:0]   mass;
        logic [RADIUS_W-1:0] radius;
    } t_entry;

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FIRST = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_PREP  = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_DIVST = 7'b0100000,
        S_DIV   = 7'b1000000
    } t_state;

endpackage

[design/icdf_table.sv]
module icdf_table #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_W-1:0]    i_wr_addr,
    input  icdf_pkg::t_entry     i_wr_data,
    input  logic [ADDR_W-1:0]    i_rd_addr,
    output icdf_pkg::t_entry     o_rd_data
);
    import icdf_pkg::*;

    // Mass and radius pairs share one word; contents are undefined until loaded.
    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/icdf_divider.sv]
module icdf_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [icdf_pkg::PROD_W-1:0]   i_dividend,
    input  logic [icdf_pkg::MASS_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [icdf_pkg::RADIUS_W-1:0] o_quotient
);
    import icdf_pkg::*;

    logic                 r_run;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [MASS_W-1:0]    r_rem;
    logic [PROD_W-1:0]    r_quo;
    logic [MASS_W-1:0]    r_div;

    logic [MASS_W:0]      trial;
    logic                 fits;

    // Restoring step: shift in one dividend bit and try to take the divisor off.
    assign trial = {r_rem, r_quo[PROD_W-1]};
    assign fits  = (trial >= {1'b0, r_div});

    // Control: run for one step per dividend bit, then pulse done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= DIV_CNT_W'(PROD_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_run) begin
            r_rem <= fits ? MASS_W'(trial - {1'b0, r_div}) : trial[MASS_W-1:0];
            r_quo <= {r_quo[PROD_W-2:0], fits};
        end
    end

    // The quotient never exceeds the radius span, so the low bits hold all of it.
    assign o_done     = r_done;
    assign o_quotient = r_quo[RADIUS_W-1:0];

endmodule

[design/inverse_cdf_radius_interpolator.sv]
// Inverse-CDF radius interpolator.
// Command channel: an item transfers at a rising edge with i_start high and o_busy low.
// i_command selects a load (entry pair written at i_entry_index) or a query
// (i_query_fraction). A load finishes at its transfer edge, returns nothing and
// leaves o_busy low, so items may follow in every cycle.
// A query raises o_busy, scans the table segments in order from the first, then
// interpolates with one 17x24 multiply and a bit-serial 41-bit division.
// Its result appears on o_radius_out and o_beyond_table for one cycle with o_done.
// A query that no segment brackets ends when the scan reaches the last segment,
// points_in_use - 1, and returns that segment's end radius with o_beyond_table;
// a hit in a zero-width segment returns its start radius without the division.
// The scan reads one table entry per cycle and the division takes one quotient
// bit per cycle.
// o_busy drops in the cycle o_done is high, so the next item can transfer then.
// The receiver cannot stall: each result is taken in the cycle it is shown.
// i_cfg_we writes points_in_use from i_cfg_data; write it only while idle.
// Synchronous reset sets points_in_use to 2 and returns the sequencer to idle;
// table contents survive reset and are undefined until loaded.
module inverse_cdf_radius_interpolator #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_command,
    input  logic [icdf_pkg::INDEX_W-1:0]  i_entry_index,
    input  logic [icdf_pkg::MASS_W-1:0]   i_entry_mass_fraction,
    input  logic [icdf_pkg::RADIUS_W-1:0] i_entry_radius,
    input  logic [icdf_pkg::MASS_W-1:0]   i_query_fraction,
    input  logic                          i_cfg_we,
    input  logic [icdf_pkg::PTS_W-1:0]    i_cfg_data,
    output logic                          o_done,
    output logic [icdf_pkg::RADIUS_W-1:0] o_radius_out,
    output logic                          o_beyond_table
);
    import icdf_pkg::*;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    // Control registers.
    t_state             r_state, n_state;
    logic               r_done, n_done;
    logic [PTS_W-1:0]   r_points;

    // Payload registers.
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_last, n_last;
    logic [MASS_W-1:0]  r_q, n_q;
    logic [MASS_W-1:0]  r_m0, n_m0, r_m1, n_m1;
    logic [RADIUS_W-1:0] r_r0, n_r0, r_r1, n_r1;
    logic [MASS_W-1:0]  r_d, n_d, r_w, n_w;
    logic [RADIUS_W-1:0] r_span, n_span;
    logic               r_dir, n_dir;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [RADIUS_W-1:0] r_radius, n_radius;
    logic               r_beyond, n_beyond;

    logic               accept;
    logic               load_wr;
    logic [CNT_W-1:0]   pts_clamped;
    logic [ADDR_W-1:0]  rd_addr;
    t_entry             rd_data;
    t_entry             wr_data;
    logic               div_start;
    logic               div_done;
    logic [RADIUS_W-1:0] div_quo;

    assign accept  = i_start && (r_state == S_IDLE);
    assign load_wr = accept && (i_command == CMD_LOAD)
                     && (32'(i_entry_index) < TABLE_DEPTH);
    assign wr_data = '{mass: i_entry_mass_fraction, radius: i_entry_radius};

    // Idle keeps entry 0 on the read port so a query starts without a wait.
    assign rd_addr   = (r_state == S_IDLE) ? '0 : r_idx[ADDR_W-1:0];
    assign div_start = (r_state == S_DIVST);

    // Point count clamped to the table's valid range.
    always_comb begin
        if (r_points < PTS_W'(2)) begin
            pts_clamped = CNT_W'(2);
        end else if (32'(r_points) > TABLE_DEPTH) begin
            pts_clamped = CNT_W'(TABLE_DEPTH);
        end else begin
            pts_clamped = CNT_W'(r_points);
        end
    end

    icdf_table #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (load_wr),
        .i_wr_addr (ADDR_W'(i_entry_index)),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    icdf_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_w),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Sequencer: scan segments one entry per cycle, then interpolate.
    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_idx    = r_idx;
        n_last   = r_last;
        n_q      = r_q;
        n_m0     = r_m0;
        n_m1     = r_m1;
        n_r0     = r_r0;
        n_r1     = r_r1;
        n_d      = r_d;
        n_w      = r_w;
        n_span   = r_span;
        n_dir    = r_dir;
        n_prod   = r_prod;
        n_radius = r_radius;
        n_beyond = r_beyond;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_command == CMD_QUERY)) begin
                    n_q     = i_query_fraction;
                    n_last  = pts_clamped - CNT_W'(1);
                    n_idx   = CNT_W'(1);
                    n_state = S_FIRST;
                end
            end
            S_FIRST: begin
                // Entry 0 arrives; entry 1 is being read.
                n_m0    = rd_data.mass;
                n_r0    = rd_data.radius;
                n_idx   = r_idx + CNT_W'(1);
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // rd_data is the end entry of the segment under test.
                if ((r_q >= r_m0) && (r_q <= rd_data.mass)) begin
                    n_m1    = rd_data.mass;
                    n_r1    = rd_data.radius;
                    n_state = S_PREP;
                end else if ((r_idx - CNT_W'(1)) == r_last) begin
                    n_radius = rd_data.radius;
                    n_beyond = 1'b1;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_m0  = rd_data.mass;
                    n_r0  = rd_data.radius;
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            S_PREP: begin
                // A zero-width segment returns its start radius.
                n_d    = r_q - r_m0;
                n_w    = r_m1 - r_m0;
                n_dir  = (r_r1 >= r_r0);
                n_span = (r_r1 >= r_r0) ? (r_r1 - r_r0) : (r_r0 - r_r1);
                if (r_m1 == r_m0) begin
                    n_radius = r_r0;
                    n_beyond = 1'b0;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = PROD_W'(r_d) * PROD_W'(r_span);
                n_state = S_DIVST;
            end
            S_DIVST: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                // Offset truncates toward the start radius.
                if (div_done) begin
                    n_radius = r_dir ? (r_r0 + div_quo) : (r_r0 - div_quo);
                    n_beyond = 1'b0;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_points <= PTS_W'(2);
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_points <= i_cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_last   <= n_last;
        r_q      <= n_q;
        r_m0     <= n_m0;
        r_m1     <= n_m1;
        r_r0     <= n_r0;
        r_r1     <= n_r1;
        r_d      <= n_d;
        r_w      <= n_w;
        r_span   <= n_span;
        r_dir    <= n_dir;
        r_prod   <= n_prod;
        r_radius <= n_radius;
        r_beyond <= n_beyond;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_radius_out   = r_radius;
    assign o_beyond_table = r_beyond;

endmodule

[design/icdf_checker.sv]
module icdf_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_command,
    input  logic o_busy,
    input  logic o_done
);
    import icdf_pkg::*;

    // A load transfer never occupies the block.
    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_command == CMD_LOAD)) |=> !o_busy)
        else $error("load transfer left the block busy");

    // A query transfer always occupies the block in the next cycle.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_command == CMD_QUERY)) |=> o_busy)
        else $error("query transfer did not make the block busy");

    // A result ends a busy period and frees the command channel at once.
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!o_busy && $past(o_busy)))
        else $error("result not at the end of a busy period");

    // Each result is shown for a single cycle.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

endmodule

bind inverse_cdf_radius_interpolator icdf_checker u_icdf_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_start   (i_start),
    .i_command (i_command),
    .o_busy    (o_busy),
    .o_done    (o_done)
);

[dv/icdf_checker.sv]
`timescale 1ns / 1ps

module icdf_scoreboard #(
    parameter int DEPTH = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic                          i_command,
    input  logic [icdf_pkg::INDEX_W-1:0]  i_entry_index,
    input  logic [icdf_pkg::MASS_W-1:0]   i_entry_mass_fraction,
    input  logic [icdf_pkg::RADIUS_W-1:0] i_entry_radius,
    input  logic [icdf_pkg::MASS_W-1:0]   i_query_fraction,
    input  logic                          i_cfg_we,
    input  logic [icdf_pkg::PTS_W-1:0]    i_cfg_data,
    input  logic                          i_done,
    input  logic [icdf_pkg::RADIUS_W-1:0] i_radius_out,
    input  logic                          i_beyond_table,
    output int                            o_outstanding,
    output int                            o_fail_count
);
    import icdf_pkg::*;

    // One predicted answer to a radius query.
    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic                beyond;
    } t_answer;

    logic [MASS_W-1:0]   mass_copy   [DEPTH];
    logic [RADIUS_W-1:0] radius_copy [DEPTH];
    logic [PTS_W-1:0]    points_copy = PTS_W'(2);
    t_answer             answers_due [$];
    int                  waiting = 0;
    int                  mismatches = 0;

    assign o_outstanding = waiting;
    assign o_fail_count  = mismatches;

    // Scan the segments in order and interpolate inside the first one that
    // brackets the fraction; with no bracketing segment, return the last radius.
    function automatic t_answer lookup_radius(input logic [MASS_W-1:0] frac);
        int unsigned         n;
        int unsigned         k;
        logic [MASS_W-1:0]   m0;
        logic [MASS_W-1:0]   m1;
        logic [RADIUS_W-1:0] r0;
        logic [RADIUS_W-1:0] r1;
        logic [PROD_W-1:0]   frac_off;
        logic [PROD_W-1:0]   span;
        logic [PROD_W-1:0]   seg_width;
        logic [PROD_W-1:0]   offset;
        t_answer             ans;
        n = points_copy;
        if (n < 2) n = 2;
        if (n > DEPTH) n = DEPTH;
        ans.radius = radius_copy[n-1];
        ans.beyond = 1'b1;
        for (k = 1; k < n && ans.beyond; k++) begin
            m0 = mass_copy[k-1];
            m1 = mass_copy[k];
            r0 = radius_copy[k-1];
            r1 = radius_copy[k];
            if (frac >= m0 && frac <= m1) begin
                ans.beyond = 1'b0;
                // A zero-width segment gives its start radius.
                if (m1 == m0) begin
                    ans.radius = r0;
                end else begin
                    frac_off  = frac - m0;
                    span      = (r1 >= r0) ? r1 - r0 : r0 - r1;
                    seg_width = m1 - m0;
                    offset    = (frac_off * span) / seg_width;
                    // Truncation is toward the start radius in both directions.
                    if (r1 >= r0) ans.radius = r0 + offset[RADIUS_W-1:0];
                    else ans.radius = r0 - offset[RADIUS_W-1:0];
                end
            end
        end
        return ans;
    endfunction

    // Follow every transfer, keep the table copy, and compare results in order.
    always @(posedge i_clk) begin
        t_answer due;
        if (!i_rst_n) begin
            points_copy = PTS_W'(2);
            answers_due.delete();
            waiting <= 0;
        end else begin
            if (i_done) begin
                if (answers_due.size() == 0) begin
                    $error("result with no query waiting: radius_out %0h beyond_table %0b",
                           i_radius_out, i_beyond_table);
                    mismatches++;
                end else begin
                    due = answers_due.pop_front();
                    if (i_radius_out !== due.radius) begin
                        $error("radius_out mismatch: expected %0h, actual %0h",
                               due.radius, i_radius_out);
                        mismatches++;
                    end
                    if (i_beyond_table !== due.beyond) begin
                        $error("beyond_table mismatch: expected %0b, actual %0b",
                               due.beyond, i_beyond_table);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we) points_copy = i_cfg_data;
            if (i_start && !i_busy) begin
                if (i_command == CMD_LOAD) begin
                    mass_copy[i_entry_index]   = i_entry_mass_fraction;
                    radius_copy[i_entry_index] = i_entry_radius;
                end else begin
                    answers_due.insert(answers_due.size(), lookup_radius(i_query_fraction));
                end
            end
            waiting <= answers_due.size();
        end
    end

endmodule

[dv/tb_inverse_cdf_radius_interpolator.sv]
`timescale 1ns / 1ps

module tb_inverse_cdf_radius_interpolator;
    import icdf_pkg::*;

    localparam int          DEPTH       = 256;
    localparam int          CYCLE_LIMIT = 1_500_000;
    localparam int unsigned FULL_MASS   = 65536;
    localparam int unsigned RADIUS_MAX  = 24'hFFFFFF;
    localparam int          PHASES      = 16;

    // How the radii of a freshly loaded table are laid out.
    typedef enum int {
        SHAPE_RISING,
        SHAPE_FALLING,
        SHAPE_SCATTERED,
        SHAPE_NOISE
    } t_shape;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                command = CMD_LOAD;
    logic [INDEX_W-1:0]  entry_index = '0;
    logic [MASS_W-1:0]   entry_mass_fraction = '0;
    logic [RADIUS_W-1:0] entry_radius = '0;
    logic [MASS_W-1:0]   query_fraction = '0;
    logic                cfg_we = 1'b0;
    logic [PTS_W-1:0]    cfg_data = '0;
    logic                done;
    logic [RADIUS_W-1:0] radius_out;
    logic                beyond_table;
    int                  outstanding;
    int                  fail_count;
    int                  cycle_count = 0;
    int                  sender_idle_pct = 0;
    int unsigned         points_now = 2;
    logic [MASS_W-1:0]   mass_shadow [DEPTH];

    // Register settings per phase; values outside 2..256 exercise the clamp.
    int unsigned phase_points [PHASES] =
        '{0, 5, 1, 16, 3, 256, 2, 40, 511, 9, 6, 4, 64, 7, 300, 12};

    always #6 clk = ~clk;

    inverse_cdf_radius_interpolator #(
        .TABLE_DEPTH(DEPTH)
    ) i_dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_start              (start),
        .o_busy               (busy),
        .i_command            (command),
        .i_entry_index        (entry_index),
        .i_entry_mass_fraction(entry_mass_fraction),
        .i_entry_radius       (entry_radius),
        .i_query_fraction     (query_fraction),
        .i_cfg_we             (cfg_we),
        .i_cfg_data           (cfg_data),
        .o_done               (done),
        .o_radius_out         (radius_out),
        .o_beyond_table       (beyond_table)
    );

    icdf_scoreboard #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_start              (start),
        .i_busy               (busy),
        .i_command            (command),
        .i_entry_index        (entry_index),
        .i_entry_mass_fraction(entry_mass_fraction),
        .i_entry_radius       (entry_radius),
        .i_query_fraction     (query_fraction),
        .i_cfg_we             (cfg_we),
        .i_cfg_data           (cfg_data),
        .i_done               (done),
        .i_radius_out         (radius_out),
        .i_beyond_table       (beyond_table),
        .o_outstanding        (outstanding),
        .o_fail_count         (fail_count)
    );

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Present one item and hold it until the transfer happens.
    task automatic transfer(input logic cmd, input logic [INDEX_W-1:0] idx,
                            input logic [MASS_W-1:0] mass, input logic [RADIUS_W-1:0] rad,
                            input logic [MASS_W-1:0] frac);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start               <= 1'b1;
        command             <= cmd;
        entry_index         <= idx;
        entry_mass_fraction <= mass;
        entry_radius        <= rad;
        query_fraction      <= frac;
        do @(posedge clk); while (busy);
    endtask

    // Write one entry pair; the query field carries junk.
    task automatic load_entry(input int unsigned k, input int unsigned m, input int unsigned r);
        mass_shadow[k] = MASS_W'(m);
        transfer(CMD_LOAD, INDEX_W'(k), MASS_W'(m), RADIUS_W'(r),
                 MASS_W'($urandom_range(FULL_MASS)));
    endtask

    // Ask for the radius of one fraction; the load fields carry junk.
    task automatic ask(input int unsigned frac);
        transfer(CMD_QUERY, INDEX_W'($urandom), MASS_W'($urandom_range(FULL_MASS)),
                 RADIUS_W'($urandom), MASS_W'(frac));
    endtask

    // Stop sending and wait until every query has been answered.
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (busy || outstanding != 0);
        repeat (8) @(posedge clk);
    endtask

    // Write the point count; only called while the block is idle.
    task automatic write_points(input int unsigned value);
        cfg_we   <= 1'b1;
        cfg_data <= PTS_W'(value);
        @(posedge clk);
        cfg_we   <= 1'b0;
        points_now = (value < 2) ? 2 : (value > DEPTH) ? DEPTH : value;
    endtask

    // Load entries 0 .. n-1 with rising masses, or with noise for broken tables.
    task automatic build_table(input int unsigned n, input t_shape shape);
        int unsigned base;
        int unsigned step;
        int unsigned rstep;
        int unsigned m;
        int unsigned r;
        int unsigned k;
        base  = ($urandom_range(3) == 0) ? $urandom_range(30000) : 0;
        step  = ($urandom_range(1) ? (FULL_MASS - base) : (FULL_MASS - base) * 3 / 4) / (n - 1);
        rstep = RADIUS_MAX / (n - 1);
        m     = base;
        r     = ($urandom_range(3) == 0) ? 0 : $urandom_range(rstep);
        for (k = 0; k < n; k++) begin
            case (shape)
                SHAPE_RISING:    load_entry(k, m, r);
                SHAPE_FALLING:   load_entry(k, m, RADIUS_MAX - r);
                SHAPE_SCATTERED: load_entry(k, m, $urandom);
                default:         load_entry(k, $urandom_range(FULL_MASS), $urandom);
            endcase
            // An occasional zero step leaves a zero-width segment.
            m += ($urandom_range(7) == 0) ? 0 : $urandom_range(2 * step);
            if (m > FULL_MASS) m = FULL_MASS;
            r += $urandom_range(rstep);
            if (r > RADIUS_MAX) r = RADIUS_MAX;
        end
    endtask

    // Favor fractions on and next to the table masses, plus both ends.
    function automatic int unsigned pick_query(input int unsigned n);
        int unsigned k;
        int unsigned frac;
        k = $urandom_range(n - 1);
        case ($urandom_range(7))
            0:       frac = mass_shadow[k];
            1:       frac = (mass_shadow[k] == 0) ? 0 : mass_shadow[k] - 1;
            2:       frac = (mass_shadow[k] >= FULL_MASS) ? FULL_MASS : mass_shadow[k] + 1;
            3:       frac = 0;
            4:       frac = FULL_MASS;
            default: frac = $urandom_range(FULL_MASS);
        endcase
        return frac;
    endfunction

    initial begin
        int unsigned ph;
        int unsigned j;
        int unsigned queries;
        int unsigned k;
        int unsigned lo;
        int unsigned hi;
        t_shape      shape;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_points(2);

        // Full-range table, rising radius: both ends and the middle.
        load_entry(0, 0, 0);
        load_entry(1, FULL_MASS, RADIUS_MAX);
        ask(0);
        ask(FULL_MASS);
        ask(32768);
        ask(1);
        // Falling radius.
        load_entry(0, 0, RADIUS_MAX);
        load_entry(1, FULL_MASS, 0);
        ask(12345);
        ask(FULL_MASS - 1);
        // Zero-width segment, and fractions just off it.
        load_entry(0, 1000, 500);
        load_entry(1, 1000, 9000);
        ask(1000);
        ask(999);
        ask(1001);
        // Fractions below, inside and above a narrow table.
        load_entry(0, 20000, 123456);
        load_entry(1, 40000, 77);
        ask(100);
        ask(30000);
        ask(50000);

        for (ph = 0; ph < PHASES; ph++) begin
            sender_idle_pct = (ph < 5) ? 19 : (ph < 11) ? 67 : 0;
            drain();
            write_points(phase_points[ph]);
            shape = ($urandom_range(7) == 0) ? SHAPE_NOISE : t_shape'($urandom_range(2));
            build_table(points_now, shape);
            queries = (points_now >= 64) ? 25 : 80;
            for (j = 0; j < queries; j++) begin
                // Now and then let the block run dry before going on.
                if ((ph == 3 && j == queries / 2) || $urandom_range(39) == 0) drain();
                // Rewrite a live entry, keeping the masses in order unless noisy.
                if ($urandom_range(15) == 0) begin
                    k  = $urandom_range(points_now - 1);
                    lo = (k == 0) ? 0 : mass_shadow[k-1];
                    hi = (k == points_now - 1) ? FULL_MASS : mass_shadow[k+1];
                    if (shape == SHAPE_NOISE || hi < lo)
                        load_entry(k, $urandom_range(FULL_MASS), $urandom);
                    else
                        load_entry(k, $urandom_range(hi, lo), $urandom);
                end
                ask(pick_query(points_now));
            end
        end

        drain();
        if (fail_count == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[inverse_cdf_radius_interpolator.f]
design/icdf_pkg.sv
design/icdf_table.sv
design/icdf_divider.sv
design/inverse_cdf_radius_interpolator.sv
design/icdf_checker.sv
dv/icdf_checker.sv
dv/tb_inverse_cdf_radius_interpolator.sv
